### src/iee_pkg.sv
package iee_pkg;

   // operator codes held on the operator stack
   localparam logic [2:0] OP_LP  = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_SUB = 3'd2;
   localparam logic [2:0] OP_MUL = 3'd3;
   localparam logic [2:0] OP_DIV = 3'd4;
   localparam logic [2:0] OP_POW = 3'd5;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_OPERAND  = 2'd3;

   // characters
   localparam logic [7:0] CH_POW   = 8'h5e;
   localparam logic [7:0] CH_MUL   = 8'h2a;
   localparam logic [7:0] CH_DIV   = 8'h2f;
   localparam logic [7:0] CH_ADD   = 8'h2b;
   localparam logic [7:0] CH_SUB   = 8'h2d;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int OP_WIDTH = 3;

   function automatic logic [1:0] prec(input logic [2:0] op);
      case (op)
         OP_POW:         prec = 2'd3;
         OP_MUL, OP_DIV: prec = 2'd2;
         OP_ADD, OP_SUB: prec = 2'd1;
         default:        prec = 2'd0;
      endcase
   endfunction

endpackage

### src/iee_if.sv
interface iee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;
   modport source (output valid, char_code, is_last, input ready);
   modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface iee_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  error_code;
   modport source (output valid, value, error_code, input ready);
   modport sink   (input valid, value, error_code, output ready);
endinterface

### src/iee_ram.sv
module iee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### src/iee_alu.sv
module iee_alu #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             op,
   input  logic [VALUE_WIDTH-1:0] a,
   input  logic [VALUE_WIDTH-1:0] b,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result,
   output logic                   div_zero
);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic [2:0]             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;    // product / quotient / power result
   logic [VALUE_WIDTH-1:0] x_ff, x_in;        // multiplicand / dividend / base
   logic [VALUE_WIDTH-1:0] y_ff, y_in;        // multiplier / divisor / exponent
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH-1:0] res_ff, res_in;
   logic                   dz_ff, dz_in;

   logic [VALUE_WIDTH-1:0] ma, mb, rem_sh;
   logic [VALUE_WIDTH:0]   rem_try;

   assign ma = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
   assign mb = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;
   assign rem_sh  = {rem_ff[VALUE_WIDTH-2:0], x_ff[VALUE_WIDTH-1]};
   assign rem_try = {1'b0, rem_sh} - {1'b0, y_ff};

   // add/sub done at start; iterative shift-add multiply, restoring divide, square-multiply power
   always_comb begin
      busy_in = busy_ff; op_in = op_ff; acc_in = acc_ff; x_in = x_ff; y_in = y_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; neg_in = neg_ff; done_in = 1'b0;
      res_in = res_ff; dz_in = dz_ff;
      if (start) begin
         op_in = op; x_in = a; y_in = b; acc_in = '0; rem_in = '0; dz_in = 1'b0;
         cnt_in = CW'(VALUE_WIDTH); neg_in = 1'b0; busy_in = 1'b1;
         case (op)
            iee_pkg::OP_ADD: begin res_in = a + b; busy_in = 1'b0; done_in = 1'b1; end
            iee_pkg::OP_SUB: begin res_in = a - b; busy_in = 1'b0; done_in = 1'b1; end
            iee_pkg::OP_DIV: begin
               if (b == '0) begin
                  res_in = '0; dz_in = 1'b1; busy_in = 1'b0; done_in = 1'b1;
               end else begin
                  x_in = ma; y_in = mb; neg_in = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
               end
            end
            iee_pkg::OP_POW: begin
               acc_in = VALUE_WIDTH'(1);
               if (b[VALUE_WIDTH-1]) begin
                  res_in = VALUE_WIDTH'(1); busy_in = 1'b0; done_in = 1'b1;
               end
            end
            iee_pkg::OP_MUL: ;
            default: begin res_in = '0; busy_in = 1'b0; done_in = 1'b1; end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            iee_pkg::OP_DIV: begin
               x_in = {x_ff[VALUE_WIDTH-2:0], 1'b0};
               if (!rem_try[VALUE_WIDTH]) begin
                  rem_in = rem_try[VALUE_WIDTH-1:0];
                  acc_in = {acc_ff[VALUE_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  acc_in = {acc_ff[VALUE_WIDTH-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  busy_in = 1'b0; done_in = 1'b1;
                  res_in = neg_ff ? (~acc_in + 1'b1) : acc_in;
               end
            end
            iee_pkg::OP_POW: begin
               if (y_ff == '0) begin
                  busy_in = 1'b0; done_in = 1'b1; res_in = acc_ff;
               end else begin
                  if (y_ff[0]) acc_in = acc_ff * x_ff;
                  x_in = x_ff * x_ff;
                  y_in = y_ff >> 1;
               end
            end
            default: begin
               // multiply, one bit a cycle
               if (y_ff == '0) begin
                  busy_in = 1'b0; done_in = 1'b1; res_in = acc_ff;
               end else begin
                  if (y_ff[0]) acc_in = acc_ff + x_ff;
                  x_in = x_ff << 1;
                  y_in = y_ff >> 1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in; acc_ff <= acc_in; x_ff <= x_in; y_ff <= y_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; res_ff <= res_in; dz_ff <= dz_in;
   end

   assign done     = done_ff;
   assign result   = res_ff;
   assign div_zero = dz_ff;
endmodule

### src/infix_expression_evaluator_top.sv
// a digit, '(' or ignored item is decoded and finished before the next accept, an
// operator or ')' also reads the operator stack; each operator applied reads two values
// and runs the arithmetic unit (add/sub, multiply, divide, power); the last item adds
// the drain and the output state
// throughput: one item at a time, set by the stack memories' read latency and the ALU
// reset: synchronous, active high; clears counts, sticky error and control
module infix_expression_evaluator_top #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   iee_req_if.sink   req,
   iee_rsp_if.source rsp
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_OPRD  = 10'b0000000100,  // operator top read in flight
      S_OPCHK = 10'b0000001000,
      S_VRD1  = 10'b0000010000,  // value b arrives
      S_VRD2  = 10'b0000100000,  // read value a
      S_ALU   = 10'b0001000000,
      S_WAIT  = 10'b0010000000,
      S_FIN   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      M_RPAREN = 2'd0,
      M_OPER   = 2'd1,
      M_DRAIN  = 2'd2
   } mode_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [CW-1:0]          vcnt_ff, vcnt_in, ocnt_ff, ocnt_in;
   logic [1:0]             err_ff, err_in;
   logic [7:0]             ch_ff, ch_in;
   logic                   last_ff, last_in;
   logic [2:0]             newop_ff, newop_in;
   logic [2:0]             top_ff, top_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_err_ff, rsp_err_in;

   logic                   vwe, owe;
   logic [AW-1:0]          vwa, vra, owa, ora;
   logic [VALUE_WIDTH-1:0] vwd, vrd;
   logic [2:0]             owd, ord;
   logic                   alu_start, alu_done, alu_dz;
   logic [VALUE_WIDTH-1:0] alu_res;
   logic [1:0]             err_set;

   iee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_vstack (
      .clock(clock), .wr_en(vwe), .wr_addr(vwa), .wr_data(vwd),
      .rd_addr(vra), .rd_data(vrd)
   );
   iee_ram #(.WIDTH(iee_pkg::OP_WIDTH), .DEPTH(STACK_DEPTH)) u_ostack (
      .clock(clock), .wr_en(owe), .wr_addr(owa), .wr_data(owd),
      .rd_addr(ora), .rd_data(ord)
   );
   iee_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(top_ff),
      .a(vrd), .b(b_ff), .done(alu_done), .result(alu_res), .div_zero(alu_dz)
   );

   assign req.ready      = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.value      = rsp_value_ff;
   assign rsp.error_code = rsp_err_ff;

   // sequencer over the two stacks
   always_comb begin
      state_in = state_ff; mode_in = mode_ff; vcnt_in = vcnt_ff; ocnt_in = ocnt_ff;
      err_set = iee_pkg::ERR_NONE; ch_in = ch_ff; last_in = last_ff;
      newop_in = newop_ff; top_in = top_ff; b_in = b_ff;
      rsp_valid_in = rsp_valid_ff; rsp_value_in = rsp_value_ff; rsp_err_in = rsp_err_ff;
      vwe = 1'b0; vwa = AW'(vcnt_ff); vwd = '0;
      owe = 1'b0; owa = AW'(ocnt_ff); owd = '0;
      vra = AW'(vcnt_ff - 1'b1); ora = AW'(ocnt_ff - 1'b1);
      alu_start = 1'b0;

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               ch_in = req.char_code; last_in = req.is_last; state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_FIN;
            if (ch_ff >= iee_pkg::CH_ZERO && ch_ff <= iee_pkg::CH_NINE) begin
               if (vcnt_ff >= CW'(STACK_DEPTH)) err_set = iee_pkg::ERR_OVERFLOW;
               else begin
                  vwe = 1'b1;
                  vwd = VALUE_WIDTH'(ch_ff - iee_pkg::CH_ZERO);
                  vcnt_in = vcnt_ff + 1'b1;
               end
            end else if (ch_ff == iee_pkg::CH_LP) begin
               if (ocnt_ff >= CW'(STACK_DEPTH)) err_set = iee_pkg::ERR_OVERFLOW;
               else begin
                  owe = 1'b1; owd = iee_pkg::OP_LP; ocnt_in = ocnt_ff + 1'b1;
               end
            end else if (ch_ff == iee_pkg::CH_RP) begin
               mode_in = M_RPAREN; state_in = S_OPRD;
            end else begin
               case (ch_ff)
                  iee_pkg::CH_ADD: begin newop_in = iee_pkg::OP_ADD; mode_in = M_OPER;
                                         state_in = S_OPRD; end
                  iee_pkg::CH_SUB: begin newop_in = iee_pkg::OP_SUB; mode_in = M_OPER;
                                         state_in = S_OPRD; end
                  iee_pkg::CH_MUL: begin newop_in = iee_pkg::OP_MUL; mode_in = M_OPER;
                                         state_in = S_OPRD; end
                  iee_pkg::CH_DIV: begin newop_in = iee_pkg::OP_DIV; mode_in = M_OPER;
                                         state_in = S_OPRD; end
                  iee_pkg::CH_POW: begin newop_in = iee_pkg::OP_POW; mode_in = M_OPER;
                                         state_in = S_OPRD; end
                  default: ;
               endcase
            end
         end
         S_OPRD: begin
            // operator top read issued with ora; data next cycle
            state_in = S_OPCHK;
         end
         S_OPCHK: begin
            top_in = ord;
            if (ocnt_ff == '0) begin
               if (mode_ff == M_OPER) begin
                  owe = 1'b1; owd = newop_ff; ocnt_in = ocnt_ff + 1'b1;
               end
               state_in = S_FIN;
            end else if (ord == iee_pkg::OP_LP) begin
               if (mode_ff == M_OPER) begin
                  if (ocnt_ff >= CW'(STACK_DEPTH)) err_set = iee_pkg::ERR_OVERFLOW;
                  else begin
                     owe = 1'b1; owd = newop_ff; ocnt_in = ocnt_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end else if (mode_ff == M_RPAREN) begin
                  ocnt_in = ocnt_ff - 1'b1; state_in = S_FIN;
               end else begin
                  ocnt_in = ocnt_ff - 1'b1; state_in = S_OPRD;
               end
            end else if (mode_ff == M_OPER &&
                         iee_pkg::prec(newop_ff) > iee_pkg::prec(ord)) begin
               if (ocnt_ff >= CW'(STACK_DEPTH)) err_set = iee_pkg::ERR_OVERFLOW;
               else begin
                  owe = 1'b1; owd = newop_ff; ocnt_in = ocnt_ff + 1'b1;
               end
               state_in = S_FIN;
            end else begin
               // pop the top operator; apply it if two values are on the stack
               ocnt_in = ocnt_ff - 1'b1;
               if (vcnt_ff < CW'(2)) begin
                  err_set = iee_pkg::ERR_OPERAND; state_in = S_OPRD;
               end else begin
                  state_in = S_VRD1;
               end
            end
         end
         S_VRD1: begin
            // b arrives from vcnt-1; issue a read at vcnt-2
            b_in = vrd;
            vra = AW'(vcnt_ff - CW'(2));
            state_in = S_VRD2;
         end
         S_VRD2: begin
            vra = AW'(vcnt_ff - CW'(2));
            state_in = S_ALU;
         end
         S_ALU: begin
            alu_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (alu_done) begin
               if (alu_dz) err_set = iee_pkg::ERR_DIV_ZERO;
               vwe = 1'b1; vwa = AW'(vcnt_ff - CW'(2)); vwd = alu_res;
               vcnt_in = vcnt_ff - 1'b1;
               state_in = S_OPRD;
            end
         end
         S_FIN: begin
            // end of character; drain if last
            if (last_ff) begin
               if (ocnt_ff != '0) begin
                  mode_in = M_DRAIN; state_in = S_OPRD;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            // top value read issued at vcnt-1 in S_FIN, or in S_OPCHK when a drain ends
            rsp_valid_in = 1'b1;
            if (vcnt_ff == '0) begin
               rsp_value_in = '0;
               rsp_err_in = (err_ff == iee_pkg::ERR_NONE) ? iee_pkg::ERR_OPERAND : err_ff;
            end else begin
               rsp_value_in = 32'(signed'(vrd));
               rsp_err_in = err_ff;
            end
            vcnt_in = '0; ocnt_in = '0; last_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // drain ends by returning through S_OPCHK with an empty stack
      if (state_ff == S_OPCHK && mode_ff == M_DRAIN && ocnt_ff == '0) state_in = S_OUT;
      if (state_ff == S_OPCHK && mode_ff == M_DRAIN && ocnt_ff == '0) begin
         vra = AW'(vcnt_ff - 1'b1);
      end

      err_in = err_ff;
      if (state_ff == S_OUT) err_in = iee_pkg::ERR_NONE;
      else if (err_ff == iee_pkg::ERR_NONE) err_in = err_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_OPER;
         vcnt_ff      <= '0;
         ocnt_ff      <= '0;
         err_ff       <= iee_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         vcnt_ff      <= vcnt_in;
         ocnt_ff      <= ocnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
      ch_ff <= ch_in; newop_ff <= newop_in; top_ff <= top_in; b_ff <= b_in;
      rsp_value_ff <= rsp_value_in; rsp_err_ff <= rsp_err_in;
   end
endmodule

### src/iee_checker.sv
module iee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [1:0]  rsp_error_code
);
   // no new item taken while a result waits
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("item accepted while result pending");

   // a rising result is never directly preceded by an accepted item
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_error_code))
      else $error("result changed under stall");
endmodule

bind infix_expression_evaluator_top iee_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_value(rsp.value), .rsp_error_code(rsp.error_code)
);
